// ===== hdl/rvcsr_pkg.sv =====
// package for the rv32 csr register file: beat types, command codes and csr addresses
`timescale 1ns / 1ps
`default_nettype none
package rvcsr_pkg;

	localparam int unsigned XLEN        = 32;
	localparam int unsigned CNT_WIDTH   = 64;
	localparam int unsigned ADDR_WIDTH  = 12;
	localparam int unsigned PRIV_WIDTH  = 2;
	localparam int unsigned CMD_WIDTH   = 2;
	localparam int unsigned CFG_IDX_W   = 3;

	localparam logic [CMD_WIDTH-1:0] CMD_READ  = 2'd0;
	localparam logic [CMD_WIDTH-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_WIDTH-1:0] CMD_TICK  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SSTATUS_MASK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MSTATUS_MASK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SATP_MASK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIE_MASK     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIP_MASK     = 3'd4;

	localparam logic [XLEN-1:0] MISA_VALUE = 32'h4014_1101;
	localparam logic [1:0]      MPP_RESERVED = 2'd2;

	localparam logic [ADDR_WIDTH-1:0] CSR_CYCLE         = 12'hC00;
	localparam logic [ADDR_WIDTH-1:0] CSR_INSTRET       = 12'hC02;
	localparam logic [ADDR_WIDTH-1:0] CSR_CYCLEH        = 12'hC80;
	localparam logic [ADDR_WIDTH-1:0] CSR_INSTRETH      = 12'hC82;
	localparam logic [ADDR_WIDTH-1:0] CSR_MCYCLE        = 12'hB00;
	localparam logic [ADDR_WIDTH-1:0] CSR_MINSTRET      = 12'hB02;
	localparam logic [ADDR_WIDTH-1:0] CSR_MCYCLEH       = 12'hB80;
	localparam logic [ADDR_WIDTH-1:0] CSR_MINSTRETH     = 12'hB82;
	localparam logic [ADDR_WIDTH-1:0] CSR_SSTATUS       = 12'h100;
	localparam logic [ADDR_WIDTH-1:0] CSR_SIE           = 12'h104;
	localparam logic [ADDR_WIDTH-1:0] CSR_STVEC         = 12'h105;
	localparam logic [ADDR_WIDTH-1:0] CSR_SCOUNTEREN    = 12'h106;
	localparam logic [ADDR_WIDTH-1:0] CSR_SSCRATCH      = 12'h140;
	localparam logic [ADDR_WIDTH-1:0] CSR_SEPC          = 12'h141;
	localparam logic [ADDR_WIDTH-1:0] CSR_SCAUSE        = 12'h142;
	localparam logic [ADDR_WIDTH-1:0] CSR_STVAL         = 12'h143;
	localparam logic [ADDR_WIDTH-1:0] CSR_SIP           = 12'h144;
	localparam logic [ADDR_WIDTH-1:0] CSR_SATP          = 12'h180;
	localparam logic [ADDR_WIDTH-1:0] CSR_MVENDORID     = 12'hF11;
	localparam logic [ADDR_WIDTH-1:0] CSR_MARCHID       = 12'hF12;
	localparam logic [ADDR_WIDTH-1:0] CSR_MIMPID        = 12'hF13;
	localparam logic [ADDR_WIDTH-1:0] CSR_MHARTID       = 12'hF14;
	localparam logic [ADDR_WIDTH-1:0] CSR_MSTATUS       = 12'h300;
	localparam logic [ADDR_WIDTH-1:0] CSR_MISA          = 12'h301;
	localparam logic [ADDR_WIDTH-1:0] CSR_MIE           = 12'h304;
	localparam logic [ADDR_WIDTH-1:0] CSR_MTVEC         = 12'h305;
	localparam logic [ADDR_WIDTH-1:0] CSR_MCOUNTEREN    = 12'h306;
	localparam logic [ADDR_WIDTH-1:0] CSR_MCOUNTINHIBIT = 12'h320;
	localparam logic [ADDR_WIDTH-1:0] CSR_MSCRATCH      = 12'h340;
	localparam logic [ADDR_WIDTH-1:0] CSR_MEPC          = 12'h341;
	localparam logic [ADDR_WIDTH-1:0] CSR_MCAUSE        = 12'h342;
	localparam logic [ADDR_WIDTH-1:0] CSR_MTVAL         = 12'h343;
	localparam logic [ADDR_WIDTH-1:0] CSR_MIP           = 12'h344;
	localparam logic [ADDR_WIDTH-1:0] CSR_PMPCFG_LO     = 12'h3A0;
	localparam logic [ADDR_WIDTH-1:0] CSR_PMPCFG_HI     = 12'h3A3;
	localparam logic [ADDR_WIDTH-1:0] CSR_PMPADDR_LO    = 12'h3B0;
	localparam logic [ADDR_WIDTH-1:0] CSR_PMPADDR_HI    = 12'h3BF;

	typedef struct packed {
		logic [CMD_WIDTH-1:0]  command;
		logic [ADDR_WIDTH-1:0] csr_address;
		logic [XLEN-1:0]       write_value;
		logic [PRIV_WIDTH-1:0] current_privilege;
	} csr_req_t;

	typedef struct packed {
		logic [XLEN-1:0] read_value;
		logic            access_ok;
	} csr_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/rv32_csr_register_file.sv =====
// rv32 machine and supervisor csr register file with 64-bit cycle and instret counters
//
// Each request beat (read, write or counter tick) is captured in an input register and
// resolved by a single pass of decode and update logic, which writes the csr state and
// the response register together. One beat is taken per cycle while the output side
// does not stall; the response is presented from the response register, and the input
// stalls while a held response is stalled at the output.
// The limit is the 64-bit counter increment and the address decode feeding the state
// update. The write masks reset to all ones and are to be set by the user through the
// configuration port while no beat is in flight, which the block does not enforce.
`timescale 1ns / 1ps
`default_nettype none
module rv32_csr_register_file (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write,
	input  wire logic [rvcsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rvcsr_pkg::XLEN-1:0]           cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire rvcsr_pkg::csr_req_t                  in_beat,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output rvcsr_pkg::csr_rsp_t                       out_beat
);
	import rvcsr_pkg::*;

	logic [XLEN-1:0] sstatus_mask_q, mstatus_mask_q, satp_mask_q, mie_mask_q, mip_mask_q;

	logic [XLEN-1:0] sstatus_q, sscratch_q, sepc_q, satp_q;
	logic [XLEN-1:0] mstatus_q, mie_q, mtvec_q, mscratch_q;
	logic [XLEN-1:0] mepc_q, mcause_q, mtval_q, mip_q;
	logic [CNT_WIDTH-1:0] cycle_q, instret_q;

	logic     valid_s1;
	csr_req_t req_s1;
	logic     out_valid_q;
	csr_rsp_t out_beat_q;

	logic advance;
	logic mapped;
	logic priv_ok;
	logic ok;
	logic do_write;
	logic do_tick;
	logic [XLEN-1:0] cur_val;
	logic [XLEN-1:0] wv;
	logic [XLEN-1:0] mstatus_wv;
	logic [XLEN-1:0] mtvec_wv;
	csr_rsp_t rsp;

	logic [XLEN-1:0] sstatus_d, sscratch_d, sepc_d, satp_d;
	logic [XLEN-1:0] mstatus_d, mie_d, mtvec_d, mscratch_d;
	logic [XLEN-1:0] mepc_d, mcause_d, mtval_d, mip_d;
	logic [CNT_WIDTH-1:0] cycle_d, instret_d;

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = !advance;
	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

	// address decode and read mux
	always_comb begin
		mapped  = 1'b1;
		cur_val = '0;
		unique case (req_s1.csr_address) inside
			CSR_CYCLE, CSR_MCYCLE:       cur_val = cycle_q[XLEN-1:0];
			CSR_INSTRET, CSR_MINSTRET:   cur_val = instret_q[XLEN-1:0];
			CSR_CYCLEH, CSR_MCYCLEH:     cur_val = cycle_q[CNT_WIDTH-1:XLEN];
			CSR_INSTRETH, CSR_MINSTRETH: cur_val = instret_q[CNT_WIDTH-1:XLEN];
			CSR_SSTATUS:                 cur_val = sstatus_q;
			CSR_SSCRATCH:                cur_val = sscratch_q;
			CSR_SEPC:                    cur_val = sepc_q;
			CSR_SATP:                    cur_val = satp_q;
			CSR_MSTATUS:                 cur_val = mstatus_q;
			CSR_MISA:                    cur_val = MISA_VALUE;
			CSR_MIE:                     cur_val = mie_q;
			CSR_MTVEC:                   cur_val = mtvec_q;
			CSR_MSCRATCH:                cur_val = mscratch_q;
			CSR_MEPC:                    cur_val = mepc_q;
			CSR_MCAUSE:                  cur_val = mcause_q;
			CSR_MTVAL:                   cur_val = mtval_q;
			CSR_MIP:                     cur_val = mip_q;
			CSR_SIE, CSR_STVEC, CSR_SCOUNTEREN, CSR_SCAUSE, CSR_STVAL, CSR_SIP,
			CSR_MVENDORID, CSR_MARCHID, CSR_MIMPID, CSR_MHARTID,
			CSR_MCOUNTEREN, CSR_MCOUNTINHIBIT,
			[CSR_PMPCFG_LO:CSR_PMPCFG_HI],
			[CSR_PMPADDR_LO:CSR_PMPADDR_HI]: cur_val = '0;
			default:                     mapped = 1'b0;
		endcase
	end

	assign priv_ok = req_s1.current_privilege >= req_s1.csr_address[9:8];

	always_comb begin
		ok  = 1'b0;
		rsp = '0;
		case (req_s1.command)
			CMD_TICK: begin
				ok = 1'b1;
			end
			CMD_READ: begin
				ok = mapped && priv_ok;
				if (ok) begin
					rsp.read_value = cur_val;
				end
			end
			CMD_WRITE: begin
				ok = mapped && priv_ok;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		rsp.access_ok = ok;
	end

	assign do_write = advance && valid_s1 && ok && (req_s1.command == CMD_WRITE);
	assign do_tick  = advance && valid_s1 && (req_s1.command == CMD_TICK);
	assign wv       = req_s1.write_value;

	// reserved mpp and mtvec mode fold to zero
	always_comb begin
		mstatus_wv = wv;
		if (wv[12:11] == MPP_RESERVED) begin
			mstatus_wv[12:11] = 2'b00;
		end
		mtvec_wv = wv;
		if (wv[1]) begin
			mtvec_wv[1:0] = 2'b00;
		end
	end

	always_comb begin
		sstatus_d  = sstatus_q;
		sscratch_d = sscratch_q;
		sepc_d     = sepc_q;
		satp_d     = satp_q;
		mstatus_d  = mstatus_q;
		mie_d      = mie_q;
		mtvec_d    = mtvec_q;
		mscratch_d = mscratch_q;
		mepc_d     = mepc_q;
		mcause_d   = mcause_q;
		mtval_d    = mtval_q;
		mip_d      = mip_q;
		cycle_d    = cycle_q;
		instret_d  = instret_q;
		if (do_tick) begin
			cycle_d   = cycle_q + CNT_WIDTH'(1);
			instret_d = instret_q + CNT_WIDTH'(1);
		end
		if (do_write) begin
			case (req_s1.csr_address)
				CSR_SSTATUS: begin
					sstatus_d = wv & sstatus_mask_q;
					mstatus_d = ((mstatus_q & ~sstatus_mask_q) | (wv & sstatus_mask_q))
						& mstatus_mask_q;
				end
				CSR_MSTATUS: begin
					mstatus_d = mstatus_wv & mstatus_mask_q;
					sstatus_d = ((sstatus_q & ~mstatus_mask_q) | (mstatus_wv & mstatus_mask_q))
						& sstatus_mask_q;
				end
				CSR_SATP:      satp_d     = wv & satp_mask_q;
				CSR_MIE:       mie_d      = wv & mie_mask_q;
				CSR_MIP:       mip_d      = wv & mip_mask_q;
				CSR_MTVEC:     mtvec_d    = mtvec_wv;
				CSR_SSCRATCH:  sscratch_d = wv;
				CSR_SEPC:      sepc_d     = wv;
				CSR_MSCRATCH:  mscratch_d = wv;
				CSR_MEPC:      mepc_d     = wv;
				CSR_MCAUSE:    mcause_d   = wv;
				CSR_MTVAL:     mtval_d    = wv;
				CSR_MCYCLE:    cycle_d    = {cycle_q[CNT_WIDTH-1:XLEN], wv};
				CSR_MINSTRET:  instret_d  = {instret_q[CNT_WIDTH-1:XLEN], wv};
				CSR_MCYCLEH:   cycle_d    = {wv, cycle_q[XLEN-1:0]};
				CSR_MINSTRETH: instret_d  = {wv, instret_q[XLEN-1:0]};
				default: begin
					// read-only or zero-mapped
				end
			endcase
		end
	end

	// configuration masks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sstatus_mask_q <= '1;
			mstatus_mask_q <= '1;
			satp_mask_q    <= '1;
			mie_mask_q     <= '1;
			mip_mask_q     <= '1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SSTATUS_MASK: sstatus_mask_q <= cfg_data;
				CFG_MSTATUS_MASK: mstatus_mask_q <= cfg_data;
				CFG_SATP_MASK:    satp_mask_q    <= cfg_data;
				CFG_MIE_MASK:     mie_mask_q     <= cfg_data;
				CFG_MIP_MASK:     mip_mask_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// csr state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sstatus_q  <= '0;
			sscratch_q <= '0;
			sepc_q     <= '0;
			satp_q     <= '0;
			mstatus_q  <= '0;
			mie_q      <= '0;
			mtvec_q    <= '0;
			mscratch_q <= '0;
			mepc_q     <= '0;
			mcause_q   <= '0;
			mtval_q    <= '0;
			mip_q      <= '0;
			cycle_q    <= '0;
			instret_q  <= '0;
		end else begin
			sstatus_q  <= sstatus_d;
			sscratch_q <= sscratch_d;
			sepc_q     <= sepc_d;
			satp_q     <= satp_d;
			mstatus_q  <= mstatus_d;
			mie_q      <= mie_d;
			mtvec_q    <= mtvec_d;
			mscratch_q <= mscratch_d;
			mepc_q     <= mepc_d;
			mcause_q   <= mcause_d;
			mtval_q    <= mtval_d;
			mip_q      <= mip_d;
			cycle_q    <= cycle_d;
			instret_q  <= instret_d;
		end
	end

	// input and response valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1    <= in_valid;
				out_valid_q <= valid_s1;
			end
		end
	end

	// beat payloads
	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			req_s1 <= in_beat;
		end
		if (advance && valid_s1) begin
			out_beat_q <= rsp;
		end
	end

endmodule
`default_nettype wire

// ===== sim/rv32_csr_register_file_tb.sv =====
// self-checking testbench for the rv32 csr register file with a shadow register model
`timescale 1ns / 1ps
module rv32_csr_register_file_tb;
	import rvcsr_pkg::*;

	localparam logic [CMD_WIDTH-1:0]  CMD_NONE   = 2'd3;
	localparam logic [CFG_IDX_W-1:0]  CFG_UNUSED = 3'd7;
	localparam logic [ADDR_WIDTH-1:0] CSR_TIME   = 12'hC01;
	localparam logic [ADDR_WIDTH-1:0] CSR_TIMEH  = 12'hC81;
	localparam int KNOWN_COUNT = 35;
	localparam logic [ADDR_WIDTH-1:0] KNOWN_CSR [KNOWN_COUNT] = '{
		CSR_CYCLE, CSR_INSTRET, CSR_CYCLEH, CSR_INSTRETH,
		CSR_MCYCLE, CSR_MINSTRET, CSR_MCYCLEH, CSR_MINSTRETH,
		CSR_SSTATUS, CSR_SIE, CSR_STVEC, CSR_SCOUNTEREN, CSR_SSCRATCH,
		CSR_SEPC, CSR_SCAUSE, CSR_STVAL, CSR_SIP, CSR_SATP,
		CSR_MVENDORID, CSR_MARCHID, CSR_MIMPID, CSR_MHARTID,
		CSR_MSTATUS, CSR_MISA, CSR_MIE, CSR_MTVEC, CSR_MCOUNTEREN,
		CSR_MCOUNTINHIBIT, CSR_MSCRATCH, CSR_MEPC, CSR_MCAUSE, CSR_MTVAL,
		CSR_MIP, CSR_PMPCFG_LO, CSR_PMPCFG_HI
	};
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 250;

	class csr_shadow;
		logic [XLEN-1:0]      wmask [5];
		logic [XLEN-1:0]      sstatus_r, sscratch_r, sepc_r, satp_r;
		logic [XLEN-1:0]      mstatus_r, mie_r, mtvec_r, mscratch_r;
		logic [XLEN-1:0]      mepc_r, mcause_r, mtval_r, mip_r;
		logic [CNT_WIDTH-1:0] cycle_r, instret_r;
		csr_rsp_t             rsp_due_q [$];
		int                   failures;

		function new();
			foreach (wmask[i]) wmask[i] = '1;
			sstatus_r = '0; sscratch_r = '0; sepc_r = '0; satp_r = '0;
			mstatus_r = '0; mie_r = '0; mtvec_r = '0; mscratch_r = '0;
			mepc_r = '0; mcause_r = '0; mtval_r = '0; mip_r = '0;
			cycle_r = '0; instret_r = '0;
			failures = 0;
		endfunction

		function void set_mask(logic [CFG_IDX_W-1:0] idx, logic [XLEN-1:0] value);
			if (idx <= CFG_MIP_MASK) wmask[idx] = value;
		endfunction

		function int pending();
			return rsp_due_q.size();
		endfunction

		function void note_request(csr_req_t req);
			logic [ADDR_WIDTH-1:0] a;
			logic [XLEN-1:0]       v, cur;
			logic                  hit;
			csr_rsp_t              rsp;
			a = req.csr_address;
			v = req.write_value;
			rsp = '0;
			if (req.command == CMD_TICK) begin
				cycle_r++;
				instret_r++;
				rsp.access_ok = 1'b1;
			end else if (req.command == CMD_READ || req.command == CMD_WRITE) begin
				hit = 1'b1;
				cur = '0;
				if ((a >= CSR_PMPCFG_LO && a <= CSR_PMPCFG_HI) ||
				    (a >= CSR_PMPADDR_LO && a <= CSR_PMPADDR_HI)) begin
					cur = '0;
				end else begin
					case (a)
						CSR_CYCLE, CSR_MCYCLE:       cur = cycle_r[31:0];
						CSR_INSTRET, CSR_MINSTRET:   cur = instret_r[31:0];
						CSR_CYCLEH, CSR_MCYCLEH:     cur = cycle_r[63:32];
						CSR_INSTRETH, CSR_MINSTRETH: cur = instret_r[63:32];
						CSR_SSTATUS:  cur = sstatus_r;
						CSR_SSCRATCH: cur = sscratch_r;
						CSR_SEPC:     cur = sepc_r;
						CSR_SATP:     cur = satp_r;
						CSR_MSTATUS:  cur = mstatus_r;
						CSR_MISA:     cur = MISA_VALUE;
						CSR_MIE:      cur = mie_r;
						CSR_MTVEC:    cur = mtvec_r;
						CSR_MSCRATCH: cur = mscratch_r;
						CSR_MEPC:     cur = mepc_r;
						CSR_MCAUSE:   cur = mcause_r;
						CSR_MTVAL:    cur = mtval_r;
						CSR_MIP:      cur = mip_r;
						CSR_SIE, CSR_STVEC, CSR_SCOUNTEREN, CSR_SCAUSE, CSR_STVAL,
						CSR_SIP, CSR_MVENDORID, CSR_MARCHID, CSR_MIMPID, CSR_MHARTID,
						CSR_MCOUNTEREN, CSR_MCOUNTINHIBIT: cur = '0;
						default: hit = 1'b0;
					endcase
				end
				if (hit && req.current_privilege >= a[9:8]) begin
					rsp.access_ok = 1'b1;
					if (req.command == CMD_READ) begin
						rsp.read_value = cur;
					end else begin
						case (a)
							CSR_SSTATUS: begin
								sstatus_r = v & wmask[CFG_SSTATUS_MASK];
								mstatus_r = ((mstatus_r & ~wmask[CFG_SSTATUS_MASK]) |
								             (v & wmask[CFG_SSTATUS_MASK])) &
								            wmask[CFG_MSTATUS_MASK];
							end
							CSR_MSTATUS: begin
								if (v[12:11] == MPP_RESERVED) v[12:11] = 2'b00;
								mstatus_r = v & wmask[CFG_MSTATUS_MASK];
								sstatus_r = ((sstatus_r & ~wmask[CFG_MSTATUS_MASK]) |
								             (v & wmask[CFG_MSTATUS_MASK])) &
								            wmask[CFG_SSTATUS_MASK];
							end
							CSR_SATP: satp_r = v & wmask[CFG_SATP_MASK];
							CSR_MIE:  mie_r = v & wmask[CFG_MIE_MASK];
							CSR_MIP:  mip_r = v & wmask[CFG_MIP_MASK];
							CSR_MTVEC: begin
								if (v[1:0] >= 2'd2) v[1:0] = 2'b00;
								mtvec_r = v;
							end
							CSR_SSCRATCH:  sscratch_r = v;
							CSR_SEPC:      sepc_r = v;
							CSR_MSCRATCH:  mscratch_r = v;
							CSR_MEPC:      mepc_r = v;
							CSR_MCAUSE:    mcause_r = v;
							CSR_MTVAL:     mtval_r = v;
							CSR_MCYCLE:    cycle_r[31:0] = v;
							CSR_MINSTRET:  instret_r[31:0] = v;
							CSR_MCYCLEH:   cycle_r[63:32] = v;
							CSR_MINSTRETH: instret_r[63:32] = v;
							default: ;
						endcase
					end
				end
			end
			rsp_due_q.push_back(rsp);
		endfunction

		function void check_response(csr_rsp_t got);
			csr_rsp_t want;
			if (rsp_due_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected response beat: read_value %h access_ok %b",
					         got.read_value, got.access_ok);
				return;
			end
			want = rsp_due_q.pop_front();
			if (got.read_value !== want.read_value || got.access_ok !== want.access_ok) begin
				failures++;
				if (failures <= 10)
					$display("mismatch: read_value exp %h got %h, access_ok exp %b got %b",
					         want.read_value, got.read_value, want.access_ok, got.access_ok);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [XLEN-1:0]       cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	csr_req_t              in_beat;
	logic                  out_valid;
	logic                  out_stall;
	csr_rsp_t              out_beat;
	logic                  calm;
	csr_shadow             book;

	rv32_csr_register_file dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_beat   (in_beat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

	always #10 clk = ~clk;

	function automatic csr_req_t csr_op(logic [CMD_WIDTH-1:0] cmd, logic [ADDR_WIDTH-1:0] addr,
	                                    logic [XLEN-1:0] value, logic [PRIV_WIDTH-1:0] priv);
		csr_req_t req;
		req.command = cmd;
		req.csr_address = addr;
		req.write_value = value;
		req.current_privilege = priv;
		return req;
	endfunction

	function automatic csr_req_t random_request();
		csr_req_t req;
		int       pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) req.command = CMD_READ;
		else if (pick < 78) req.command = CMD_WRITE;
		else if (pick < 96) req.command = CMD_TICK;
		else req.command = CMD_NONE;
		pick = $urandom_range(0, 99);
		if (pick < 72) req.csr_address = KNOWN_CSR[$urandom_range(0, KNOWN_COUNT - 1)];
		else if (pick < 80) req.csr_address = CSR_PMPADDR_LO + 12'($urandom_range(0, 15));
		else if (pick < 85) req.csr_address = pick[0] ? CSR_TIME : CSR_TIMEH;
		else req.csr_address = 12'($urandom);
		pick = $urandom_range(0, 9);
		req.write_value = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
		req.current_privilege = ($urandom_range(0, 2) == 0) ? 2'($urandom) : 2'd3;
		return req;
	endfunction

	task automatic send_request(input csr_req_t req);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_beat <= req;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		book.note_request(req);
		@(posedge clk);
	endtask

	task automatic wait_for_responses();
		in_valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic configure_phase(input int phase);
		logic [CFG_IDX_W-1:0] idx_list [6];
		logic [XLEN-1:0]      value;
		int                   kind;
		idx_list = '{CFG_SSTATUS_MASK, CFG_MSTATUS_MASK, CFG_SATP_MASK,
		             CFG_MIE_MASK, CFG_MIP_MASK, CFG_UNUSED};
		foreach (idx_list[i]) begin
			kind = (phase == 0 || phase == 5) ? 1 : (phase == 1) ? 0 : $urandom_range(0, 3);
			value = (kind == 0) ? '0 : (kind == 1) ? '1 : $urandom;
			if (idx_list[i] == CFG_UNUSED) value = $urandom;
			cfg_write <= 1'b1;
			cfg_index <= idx_list[i];
			cfg_data <= value;
			book.set_mask(idx_list[i], value);
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// output side stall bursts
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n === 1'b1 && out_valid && !out_stall) book.check_response(out_beat);
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(negedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		csr_req_t directed [$];
		book = new();
		calm = 1'b0;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_beat <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		configure_phase(0);

		directed.push_back(csr_op(CMD_READ, CSR_MISA, '0, 2'd3));
		directed.push_back(csr_op(CMD_READ, CSR_TIME, '0, 2'd3));
		directed.push_back(csr_op(CMD_READ, CSR_TIMEH, '0, 2'd3));
		directed.push_back(csr_op(CMD_WRITE, CSR_MISA, '0, 2'd3));
		directed.push_back(csr_op(CMD_READ, CSR_MSTATUS, '0, 2'd1));
		directed.push_back(csr_op(CMD_READ, CSR_SSTATUS, '0, 2'd2));
		directed.push_back(csr_op(CMD_READ, CSR_MSTATUS, '0, 2'd2));
		directed.push_back(csr_op(CMD_WRITE, CSR_MSTATUS, '1, 2'd3));
		directed.push_back(csr_op(CMD_READ, CSR_SSTATUS, '0, 2'd1));
		// reserved mpp collapses to zero
		directed.push_back(csr_op(CMD_WRITE, CSR_MSTATUS, 32'h0000_1000, 2'd3));
		directed.push_back(csr_op(CMD_READ, CSR_MSTATUS, '0, 2'd3));
		directed.push_back(csr_op(CMD_WRITE, CSR_SSTATUS, '0, 2'd1));
		directed.push_back(csr_op(CMD_READ, CSR_MSTATUS, '0, 2'd3));
		// reserved trap vector modes
		directed.push_back(csr_op(CMD_WRITE, CSR_MTVEC, '1, 2'd3));
		directed.push_back(csr_op(CMD_READ, CSR_MTVEC, '0, 2'd3));
		directed.push_back(csr_op(CMD_WRITE, CSR_MTVEC, 32'h0000_0002, 2'd3));
		directed.push_back(csr_op(CMD_READ, CSR_MTVEC, '0, 2'd3));
		directed.push_back(csr_op(CMD_NONE, CSR_MSCRATCH, '1, 2'd3));
		// counter wrap
		directed.push_back(csr_op(CMD_WRITE, CSR_MCYCLE, '1, 2'd3));
		directed.push_back(csr_op(CMD_WRITE, CSR_MCYCLEH, '1, 2'd3));
		directed.push_back(csr_op(CMD_WRITE, CSR_MINSTRET, '1, 2'd3));
		directed.push_back(csr_op(CMD_WRITE, CSR_MINSTRETH, '1, 2'd3));
		directed.push_back(csr_op(CMD_TICK, 12'hFFF, '1, 2'd0));
		directed.push_back(csr_op(CMD_READ, CSR_CYCLEH, '0, 2'd0));
		directed.push_back(csr_op(CMD_READ, CSR_INSTRET, '0, 2'd0));
		directed.push_back(csr_op(CMD_WRITE, CSR_CYCLE, 32'h0000_1234, 2'd0));
		directed.push_back(csr_op(CMD_READ, 12'hFFF, '0, 2'd3));
		directed.push_back(csr_op(CMD_READ, CSR_PMPADDR_HI, '0, 2'd3));
		directed.push_back(csr_op(CMD_WRITE, CSR_SSCRATCH, '1, 2'd0));
		foreach (directed[i]) send_request(directed[i]);
		wait_for_responses();

		for (int phase = 1; phase <= 5; phase++) begin
			configure_phase(phase);
			calm = (phase == 5);
			repeat (PHASE_ITEMS) begin
				send_request(random_request());
				if (!calm && $urandom_range(0, 199) == 0) wait_for_responses();
			end
			wait_for_responses();
		end
		repeat (8) @(posedge clk);
		if (book.failures == 0 && book.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
